// ===== design/assert_macros.svh =====
// assertion helpers, empty when synthesising
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define HTRI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define HTRI_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define HTRI_ASSERT(label, clk, rst_n, prop, msg)

`define HTRI_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== design/htri_pkg.sv =====
package htri_pkg;

    localparam int VERTEX_WIDTH_DEF = 32;
    localparam int REF_WIDTH_DEF    = 16;
    localparam int NUM_CORNERS      = 8;
    localparam int SLOT_WIDTH       = 3;
    localparam int NUM_MIXERS       = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_X,
        STEP_Y,
        STEP_Z
    } step_t;

    typedef struct packed {
        logic                  load;
        logic [SLOT_WIDTH-1:0] slot;
        step_t                 step;
    } htri_ctrl_t;

endpackage

// ===== design/htri_if.sv =====
interface htri_in_if
    import htri_pkg::*;
#(
    parameter int VERTEX_WIDTH = VERTEX_WIDTH_DEF,
    parameter int REF_WIDTH    = REF_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic        [SLOT_WIDTH-1:0]   corner_slot;
    logic signed [VERTEX_WIDTH-1:0] vertex_x;
    logic signed [VERTEX_WIDTH-1:0] vertex_y;
    logic signed [VERTEX_WIDTH-1:0] vertex_z;
    logic signed [REF_WIDTH-1:0]    ref_x;
    logic signed [REF_WIDTH-1:0]    ref_y;
    logic signed [REF_WIDTH-1:0]    ref_z;

    modport source (
        output valid, opcode, corner_slot, vertex_x, vertex_y, vertex_z,
               ref_x, ref_y, ref_z,
        input  ready
    );

    modport sink (
        input  valid, opcode, corner_slot, vertex_x, vertex_y, vertex_z,
               ref_x, ref_y, ref_z,
        output ready
    );
endinterface

interface htri_out_if
    import htri_pkg::*;
#(
    parameter int VERTEX_WIDTH = VERTEX_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [VERTEX_WIDTH-1:0] phys_x;
    logic signed [VERTEX_WIDTH-1:0] phys_y;
    logic signed [VERTEX_WIDTH-1:0] phys_z;

    modport source (
        output valid, phys_x, phys_y, phys_z,
        input  ready
    );

    modport sink (
        input  valid, phys_x, phys_y, phys_z,
        output ready
    );
endinterface

// ===== design/htri_mix.sv =====
module htri_mix
    import htri_pkg::*;
#(
    parameter int VERTEX_WIDTH = VERTEX_WIDTH_DEF,
    parameter int REF_WIDTH    = REF_WIDTH_DEF
) (
    input  logic signed [VERTEX_WIDTH-1:0] a,
    input  logic signed [VERTEX_WIDTH-1:0] b,
    input  logic        [REF_WIDTH-1:0]    weight,
    output logic signed [VERTEX_WIDTH-1:0] mixed
);

    localparam int PW = VERTEX_WIDTH + REF_WIDTH + 2;

    logic signed [VERTEX_WIDTH:0] diff;
    logic signed [REF_WIDTH:0]    wide_w;
    logic signed [PW-1:0]         prod;
    logic signed [PW-1:0]         sum;

    // a + floor(w * (b - a) / 2^REF_WIDTH), stays between a and b
    always_comb
    begin
        diff   = {b[VERTEX_WIDTH-1], b} - {a[VERTEX_WIDTH-1], a};
        wide_w = {1'b0, weight};
        prod   = PW'(wide_w) * PW'(diff);
        sum    = PW'(a) + (prod >>> REF_WIDTH);
        mixed  = sum[VERTEX_WIDTH-1:0];
    end

endmodule

// ===== design/htri_lane.sv =====
module htri_lane
    import htri_pkg::*;
#(
    parameter int VERTEX_WIDTH = VERTEX_WIDTH_DEF,
    parameter int REF_WIDTH    = REF_WIDTH_DEF
) (
    input  logic                           clk,
    input  htri_ctrl_t                     ctrl,
    input  logic signed [VERTEX_WIDTH-1:0] vertex,
    input  logic        [REF_WIDTH-1:0]    weight,
    output logic signed [VERTEX_WIDTH-1:0] result
);

    logic signed [VERTEX_WIDTH-1:0] corner_reg [NUM_CORNERS];
    logic signed [VERTEX_WIDTH-1:0] edge_reg   [NUM_MIXERS];
    logic signed [VERTEX_WIDTH-1:0] mix_a      [NUM_MIXERS];
    logic signed [VERTEX_WIDTH-1:0] mix_b      [NUM_MIXERS];
    logic signed [VERTEX_WIDTH-1:0] mix_out    [NUM_MIXERS];

    genvar i;
    generate
        for (i = 0; i < NUM_MIXERS; i++)
        begin : g_mix
            // first two mixers are reused for the eta and zeta passes
            if (i < 2)
            begin : g_shared
                assign mix_a[i] = (ctrl.step == STEP_X) ? corner_reg[2*i]   : edge_reg[2*i];
                assign mix_b[i] = (ctrl.step == STEP_X) ? corner_reg[2*i+1] : edge_reg[2*i+1];
            end
            else
            begin : g_xonly
                assign mix_a[i] = corner_reg[2*i];
                assign mix_b[i] = corner_reg[2*i+1];
            end

            htri_mix #(
                .VERTEX_WIDTH (VERTEX_WIDTH),
                .REF_WIDTH    (REF_WIDTH)
            ) u_mix (
                .a      (mix_a[i]),
                .b      (mix_b[i]),
                .weight (weight),
                .mixed  (mix_out[i])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            corner_reg[ctrl.slot] <= vertex;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.step)
            STEP_X:
            begin
                edge_reg[0] <= mix_out[0];
                edge_reg[1] <= mix_out[1];
                edge_reg[2] <= mix_out[2];
                edge_reg[3] <= mix_out[3];
            end
            STEP_Y:
            begin
                edge_reg[0] <= mix_out[0];
                edge_reg[1] <= mix_out[1];
            end
            STEP_Z:
            begin
                edge_reg[0] <= mix_out[0];
            end
            default:
            begin
            end
        endcase
    end

    assign result = edge_reg[0];

endmodule

// ===== design/hex_trilinear_interpolator_top.sv =====
// Trilinear interpolator for an eight-corner hexahedron. Load items (opcode 0) write one
// corner's x, y, z into the corner registers and give no result. Evaluate items (opcode 1)
// map a Q1.15 reference point to a Q16.16 physical point. Three lanes, one per coordinate,
// each hold four mixers: the xi pass runs all four, the eta pass two and the zeta pass one,
// one pass per cycle, so an evaluate item steps through accept, xi, eta and zeta in order,
// and the next item is taken while the result moves into the output register. A result
// left waiting in the output register stalls the following evaluate at its final step
// only. A corner must be loaded before an evaluate reads it.
`include "assert_macros.svh"

module hex_trilinear_interpolator_top
    import htri_pkg::*;
#(
    parameter int VERTEX_WIDTH = VERTEX_WIDTH_DEF,
    parameter int REF_WIDTH    = REF_WIDTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    htri_in_if.sink    cmd,
    htri_out_if.source res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_XS,
        S_YS,
        S_ZS,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic                           res_valid_reg;
    logic signed [VERTEX_WIDTH-1:0] phys_x_reg;
    logic signed [VERTEX_WIDTH-1:0] phys_y_reg;
    logic signed [VERTEX_WIDTH-1:0] phys_z_reg;
    logic        [REF_WIDTH-1:0]    wx_reg;
    logic        [REF_WIDTH-1:0]    wy_reg;
    logic        [REF_WIDTH-1:0]    wz_reg;
    logic        [REF_WIDTH-1:0]    weight;
    logic signed [VERTEX_WIDTH-1:0] lane_x;
    logic signed [VERTEX_WIDTH-1:0] lane_y;
    logic signed [VERTEX_WIDTH-1:0] lane_z;
    logic                           out_free;
    logic                           take;
    logic                           is_eval;
    logic                           is_load;
    htri_ctrl_t                     ctrl;

    assign out_free  = !res_valid_reg || res.ready;
    assign cmd.ready = (state_reg == S_IDLE) || ((state_reg == S_DONE) && out_free);
    assign take      = cmd.valid && cmd.ready;
    assign is_eval   = take && (cmd.opcode == OP_EVAL);
    assign is_load   = take && (cmd.opcode == OP_LOAD);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: state_next = is_eval ? S_XS : S_IDLE;
            S_XS:   state_next = S_YS;
            S_YS:   state_next = S_ZS;
            S_ZS:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = is_eval ? S_XS : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.load = is_load;
        ctrl.slot = cmd.corner_slot;
        ctrl.step = STEP_NONE;
        weight    = wx_reg;
        unique case (state_reg)
            S_XS:
            begin
                ctrl.step = STEP_X;
                weight    = wx_reg;
            end
            S_YS:
            begin
                ctrl.step = STEP_Y;
                weight    = wy_reg;
            end
            S_ZS:
            begin
                ctrl.step = STEP_Z;
                weight    = wz_reg;
            end
            default:
            begin
                ctrl.step = STEP_NONE;
            end
        endcase
    end

    // high weight (1+r)/2 is the reference value with its sign bit flipped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (is_eval)
            begin
                wx_reg <= {~cmd.ref_x[REF_WIDTH-1], cmd.ref_x[REF_WIDTH-2:0]};
                wy_reg <= {~cmd.ref_y[REF_WIDTH-1], cmd.ref_y[REF_WIDTH-2:0]};
                wz_reg <= {~cmd.ref_z[REF_WIDTH-1], cmd.ref_z[REF_WIDTH-2:0]};
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                res_valid_reg <= 1'b1;
                phys_x_reg    <= lane_x;
                phys_y_reg    <= lane_y;
                phys_z_reg    <= lane_z;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    htri_lane #(
        .VERTEX_WIDTH (VERTEX_WIDTH),
        .REF_WIDTH    (REF_WIDTH)
    ) u_lane_x (
        .clk    (clk),
        .ctrl   (ctrl),
        .vertex (cmd.vertex_x),
        .weight (weight),
        .result (lane_x)
    );

    htri_lane #(
        .VERTEX_WIDTH (VERTEX_WIDTH),
        .REF_WIDTH    (REF_WIDTH)
    ) u_lane_y (
        .clk    (clk),
        .ctrl   (ctrl),
        .vertex (cmd.vertex_y),
        .weight (weight),
        .result (lane_y)
    );

    htri_lane #(
        .VERTEX_WIDTH (VERTEX_WIDTH),
        .REF_WIDTH    (REF_WIDTH)
    ) u_lane_z (
        .clk    (clk),
        .ctrl   (ctrl),
        .vertex (cmd.vertex_z),
        .weight (weight),
        .result (lane_z)
    );

    assign res.valid  = res_valid_reg;
    assign res.phys_x = phys_x_reg;
    assign res.phys_y = phys_y_reg;
    assign res.phys_z = phys_z_reg;

    `HTRI_ASSERT(a_eval_starts, clk, rst_n, is_eval |=> (state_reg == S_XS), "evaluate item did not start the xi pass")
    `HTRI_ASSERT(a_z_to_done, clk, rst_n, (state_reg == S_ZS) |=> (state_reg == S_DONE), "zeta pass not followed by done")
    `HTRI_ASSERT(a_result_source, clk, rst_n, $rose(res_valid_reg) |-> ($past(state_reg) == S_DONE), "result appeared without a finished evaluate")
    `HTRI_ASSERT_NEVER(a_busy_no_take, clk, rst_n, cmd.ready && (state_reg == S_DONE) && res_valid_reg && !res.ready, "item taken while result register blocked")

endmodule

// ===== sim/hex_trilinear_interpolator_top_test.sv =====
`timescale 1ns / 1ps

module hex_trilinear_interpolator_top_test;
    import htri_pkg::*;

    localparam int VW = VERTEX_WIDTH_DEF;
    localparam int RW = REF_WIDTH_DEF;

    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    localparam logic signed [VW-1:0] V_MAX  = 32'sh7fff_ffff;
    localparam logic signed [VW-1:0] V_MIN  = 32'sh8000_0000;
    localparam logic signed [VW-1:0] V_ZERO = 32'sh0000_0000;
    localparam logic signed [RW-1:0] R_MAX  = 16'sh7fff;
    localparam logic signed [RW-1:0] R_MIN  = 16'sh8000;

    localparam int RANDOM_ITEMS  = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 16;

    typedef struct {
        logic                  op;
        logic [SLOT_WIDTH-1:0] slot;
        logic signed [VW-1:0]  vx;
        logic signed [VW-1:0]  vy;
        logic signed [VW-1:0]  vz;
        logic signed [RW-1:0]  rx;
        logic signed [RW-1:0]  ry;
        logic signed [RW-1:0]  rz;
        bit                    pinned;
        logic signed [VW-1:0]  px;
        logic signed [VW-1:0]  py;
        logic signed [VW-1:0]  pz;
    } cmd_item_t;

    typedef struct {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
    } point_t;

    logic clk;
    logic rst_n;

    htri_in_if  #(.VERTEX_WIDTH(VW), .REF_WIDTH(RW)) cmd ();
    htri_out_if #(.VERTEX_WIDTH(VW))                 res ();

    hex_trilinear_interpolator_top #(
        .VERTEX_WIDTH(VW),
        .REF_WIDTH   (RW)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .res  (res)
    );

    // predictor state: corner coordinates per axis
    logic signed [VW-1:0] corner_mem [3][NUM_CORNERS];

    point_t    point_q [$];
    cmd_item_t dir_q [$];

    int errors;
    int points_checked;
    int loads_sent;
    int evals_sent;
    int burst_left;
    int in_stall_run;
    int in_stall_max;
    int out_hold_max;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("hex_trilinear_interpolator_top verification failed");
        $finish;
    end

    function automatic longint blend(longint lo, longint hi, longint w_hi);
        return (((longint'(1) <<< RW) - w_hi) * lo + w_hi * hi) >>> RW;
    endfunction

    function automatic longint high_weight(logic signed [RW-1:0] r);
        return (longint'(1) <<< (RW - 1)) + longint'(r);
    endfunction

    // xi pass blends corner pairs into edges e00..e11, then eta, then zeta
    function automatic logic signed [VW-1:0] lerp_cube(int axis, longint wx, longint wy,
                                                       longint wz);
        longint e00, e10, e01, e11, f0, f1;
        e00 = blend(corner_mem[axis][0], corner_mem[axis][1], wx);
        e10 = blend(corner_mem[axis][2], corner_mem[axis][3], wx);
        e01 = blend(corner_mem[axis][4], corner_mem[axis][5], wx);
        e11 = blend(corner_mem[axis][6], corner_mem[axis][7], wx);
        f0  = blend(e00, e10, wy);
        f1  = blend(e01, e11, wy);
        return VW'(blend(f0, f1, wz));
    endfunction

    function automatic cmd_item_t row(logic op, logic [SLOT_WIDTH-1:0] slot,
                                      logic signed [VW-1:0] vx, logic signed [VW-1:0] vy,
                                      logic signed [VW-1:0] vz, logic signed [RW-1:0] rx,
                                      logic signed [RW-1:0] ry, logic signed [RW-1:0] rz,
                                      bit pinned, logic signed [VW-1:0] px,
                                      logic signed [VW-1:0] py, logic signed [VW-1:0] pz);
        cmd_item_t it;
        it.op = op;
        it.slot = slot;
        it.vx = vx;
        it.vy = vy;
        it.vz = vz;
        it.rx = rx;
        it.ry = ry;
        it.rz = rz;
        it.pinned = pinned;
        it.px = px;
        it.py = py;
        it.pz = pz;
        return it;
    endfunction

    // append one row to the directed table
    function automatic void queue_row(cmd_item_t it);
        dir_q = {dir_q, it};
    endfunction

    function automatic logic signed [VW-1:0] rand_vertex();
        case ($urandom_range(0, 7))
            0: return V_MAX;
            1: return V_MIN;
            2: return V_ZERO;
            3: return VW'($signed($urandom_range(0, 131071)) - 65536);
            default: return VW'($urandom);
        endcase
    endfunction

    function automatic logic signed [RW-1:0] rand_ref();
        case ($urandom_range(0, 7))
            0: return R_MAX;
            1: return R_MIN;
            2: return '0;
            default: return RW'($urandom);
        endcase
    endfunction

    function automatic cmd_item_t rand_item();
        logic op;
        op = ($urandom_range(0, 99) < 35) ? OP_LOAD : OP_EVAL;
        return row(op, SLOT_WIDTH'($urandom_range(0, NUM_CORNERS - 1)),
                   rand_vertex(), rand_vertex(), rand_vertex(),
                   rand_ref(), rand_ref(), rand_ref(), 1'b0, V_ZERO, V_ZERO, V_ZERO);
    endfunction

    // update the corner copy or queue the point this item should produce
    task automatic log_accepted(input cmd_item_t it);
        point_t pt;
        longint wx, wy, wz;
        if (it.op == OP_LOAD)
        begin
            corner_mem[AX_X][it.slot] = it.vx;
            corner_mem[AX_Y][it.slot] = it.vy;
            corner_mem[AX_Z][it.slot] = it.vz;
            loads_sent++;
        end
        else
        begin
            if (it.pinned)
            begin
                pt.x = it.px;
                pt.y = it.py;
                pt.z = it.pz;
            end
            else
            begin
                wx = high_weight(it.rx);
                wy = high_weight(it.ry);
                wz = high_weight(it.rz);
                pt.x = lerp_cube(AX_X, wx, wy, wz);
                pt.y = lerp_cube(AX_Y, wx, wy, wz);
                pt.z = lerp_cube(AX_Z, wx, wy, wz);
            end
            point_q = {point_q, pt};
            evals_sent++;
        end
    endtask

    task automatic issue(input cmd_item_t it);
        cmd.valid       <= 1'b1;
        cmd.opcode      <= it.op;
        cmd.corner_slot <= it.slot;
        cmd.vertex_x    <= it.vx;
        cmd.vertex_y    <= it.vy;
        cmd.vertex_z    <= it.vz;
        cmd.ref_x       <= it.rx;
        cmd.ref_y       <= it.ry;
        cmd.ref_z       <= it.rz;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        log_accepted(it);
    endtask

    // bursts of back-to-back items, between which an idle gap may or may not be inserted
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                cmd.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic check_field(input string name, input logic signed [VW-1:0] want,
                               input logic signed [VW-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        point_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (point_q.size() == 0)
            begin
                $display("%0t: result with no point pending, expected none, actual %h %h %h",
                         $time, res.phys_x, res.phys_y, res.phys_z);
                errors++;
            end
            else
            begin
                want = point_q.pop_front();
                check_field("phys_x", want.x, res.phys_x);
                check_field("phys_y", want.y, res.phys_y);
                check_field("phys_z", want.z, res.phys_z);
            end
            points_checked <= points_checked + 1;
        end
        if (rst_n && cmd.valid && !cmd.ready)
            in_stall_run <= in_stall_run + 1;
        else
            in_stall_run <= 0;
        if (in_stall_run > in_stall_max)
            in_stall_max <= in_stall_run;
    end

    // output side: random stall phases plus one long hold-off once traffic is flowing
    initial
    begin : result_drain
        int phase_left;
        int mode;
        int hold_left;
        bit held;
        phase_left = 0;
        mode = 0;
        hold_left = 0;
        held = 1'b0;
        out_hold_max = 0;
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && points_checked >= 40)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                out_hold_max = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    phase_left = $urandom_range(8, 40);
                end
                phase_left--;
                case (mode)
                    0: res.ready <= 1'b1;
                    1: res.ready <= ($urandom_range(0, 3) != 0);
                    default: res.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        cmd_item_t it;
        errors = 0;
        points_checked = 0;
        loads_sent = 0;
        evals_sent = 0;
        burst_left = 0;
        in_stall_run = 0;
        in_stall_max = 0;
        cmd.valid = 1'b0;
        cmd.opcode = OP_LOAD;
        cmd.corner_slot = '0;
        cmd.vertex_x = '0;
        cmd.vertex_y = '0;
        cmd.vertex_z = '0;
        cmd.ref_x = '0;
        cmd.ref_y = '0;
        cmd.ref_z = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every corner gets the same extreme point, so any evaluate returns it exactly
        for (int s = 0; s < NUM_CORNERS; s++)
            queue_row(row(OP_LOAD, SLOT_WIDTH'(s), V_MAX, V_MIN, V_ZERO,
                          R_MAX, R_MIN, -16'sd1, 1'b0, V_ZERO, V_ZERO, V_ZERO));
        queue_row(row(OP_EVAL, 3'd5, V_MIN, V_MAX, -32'sd1,
                      R_MIN, R_MIN, R_MIN, 1'b1, V_MAX, V_MIN, V_ZERO));
        queue_row(row(OP_EVAL, 3'd2, V_ZERO, V_ZERO, V_ZERO,
                      R_MAX, R_MAX, R_MAX, 1'b1, V_MAX, V_MIN, V_ZERO));
        queue_row(row(OP_EVAL, 3'd7, V_MAX, V_MAX, V_MAX,
                      16'sd0, -16'sd1, 16'sd1, 1'b1, V_MAX, V_MIN, V_ZERO));
        // far corner differs; minus one on every axis still picks the near corner alone
        queue_row(row(OP_LOAD, 3'd7, V_MIN, V_MAX, -32'sd1,
                      R_MAX, R_MAX, R_MAX, 1'b0, V_ZERO, V_ZERO, V_ZERO));
        queue_row(row(OP_EVAL, 3'd7, V_ZERO, V_ZERO, V_ZERO,
                      R_MIN, R_MIN, R_MIN, 1'b1, V_MAX, V_MIN, V_ZERO));
        queue_row(row(OP_EVAL, 3'd0, V_MIN, V_MIN, V_MIN,
                      R_MAX, R_MAX, R_MAX, 1'b0, V_ZERO, V_ZERO, V_ZERO));
        queue_row(row(OP_LOAD, 3'd3, 32'sh0001_0000, -32'sh0001_0000, 32'sh7fff_0000,
                      16'sd0, 16'sd0, 16'sd0, 1'b0, V_ZERO, V_ZERO, V_ZERO));
        queue_row(row(OP_LOAD, 3'd4, -32'sd1, 32'sd1, V_MIN,
                      R_MIN, R_MAX, R_MIN, 1'b0, V_ZERO, V_ZERO, V_ZERO));
        queue_row(row(OP_EVAL, 3'd1, V_ZERO, V_ZERO, V_ZERO,
                      R_MAX, R_MIN, 16'sd0, 1'b0, V_ZERO, V_ZERO, V_ZERO));
        queue_row(row(OP_EVAL, 3'd6, V_MAX, V_MIN, V_MAX,
                      16'sd0, R_MAX, R_MIN, 1'b0, V_ZERO, V_ZERO, V_ZERO));
        queue_row(row(OP_EVAL, 3'd4, V_ZERO, V_ZERO, V_ZERO,
                      -16'sd1, 16'sd1, -16'sd32767, 1'b0, V_ZERO, V_ZERO, V_ZERO));
        queue_row(row(OP_EVAL, 3'd3, V_ZERO, V_ZERO, V_ZERO,
                      16'sd16384, -16'sd16384, R_MAX, 1'b0, V_ZERO, V_ZERO, V_ZERO));

        foreach (dir_q[i])
        begin
            pace();
            issue(dir_q[i]);
        end
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            pace();
            it = rand_item();
            issue(it);
        end
        cmd.valid <= 1'b0;

        while (point_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d corner loads and %0d evaluates, %0d points compared",
                 loads_sent, evals_sent, points_checked);
        $display("longest input stall %0d cycles under a %0d cycle output hold-off",
                 in_stall_max, out_hold_max);
        if (errors == 0)
            $display("hex_trilinear_interpolator_top verification clean");
        else
            $display("hex_trilinear_interpolator_top verification failed");
        $finish;
    end

endmodule
